// ===== rtl/rsa_mexp_pkg.sv =====
`default_nettype none

package rsa_mexp_pkg;

	localparam int MOD_BITS_DEF = 32;
	localparam int VALUE_W = 32;
	localparam int EXP_W = 32;
	localparam int OP_W = 32;
	localparam int CNT_W = $clog2(OP_W);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 2'd2;

	localparam logic [CFG_DATA_W-1:0] MODULUS_RST = 32'd3233;
	localparam logic [CFG_DATA_W-1:0] PUB_EXP_RST = 32'd17;
	localparam logic [CFG_DATA_W-1:0] PRIV_EXP_RST = 32'd2753;

	localparam logic REQ_ENCRYPT = 1'b0;
	localparam logic REQ_DECRYPT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/rsa_mexp_mulmod.sv =====
`default_nettype none

// Interleaved shift-subtract modular multiplier, one bit of a per cycle.
// Requires b < m; a may be any value.
module rsa_mexp_mulmod
	import rsa_mexp_pkg::*;
#(
	parameter int MOD_BITS = MOD_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire  [OP_W-1:0]     a,
	input  wire  [MOD_BITS-1:0] b,
	input  wire  [MOD_BITS-1:0] m,
	output logic                done,
	output logic [MOD_BITS-1:0] r
);

	localparam int T_W = MOD_BITS + 2;
	localparam int S_W = MOD_BITS + 3;

	logic [OP_W-1:0]     a_q;
	logic [MOD_BITS-1:0] b_q;
	logic [MOD_BITS-1:0] r_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                run_q;
	logic                done_q;

	logic [T_W-1:0]      t;
	logic [S_W-1:0]      s1;
	logic [S_W-1:0]      s2;
	logic [MOD_BITS-1:0] r_next;

	always_comb begin
		t = {1'b0, r_q, 1'b0} + (a_q[OP_W-1] ? T_W'(b_q) : T_W'(0));
		s1 = S_W'(t) - S_W'(m);
		s2 = S_W'(t) - S_W'({m, 1'b0});
		if (!s2[S_W-1]) begin
			r_next = s2[MOD_BITS-1:0];
		end else if (!s1[S_W-1]) begin
			r_next = s1[MOD_BITS-1:0];
		end else begin
			r_next = t[MOD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(OP_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (run_q) begin
			a_q <= {a_q[OP_W-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign done = done_q;
	assign r = r_q;

endmodule

`default_nettype wire

// ===== rtl/rsa_modular_exponentiation_top.sv =====
// Sequence: a rejected transaction returns its result in the cycle after it is accepted;
// otherwise the value is first reduced modulo m, then each exponent bit from the lowest up
// multiplies the accumulator by the base if set, and the base is squared while higher bits remain.
// Throughput: one transaction at a time; busy stays high through the result strobe, and the
// next transaction can be accepted in the cycle after it. The receiver cannot stall.
// Reset is asynchronous; it loads the default key registers and returns to idle.
`default_nettype none

module rsa_modular_exponentiation_top
	import rsa_mexp_pkg::*;
#(
	parameter int MOD_BITS = MOD_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire                   req_type,
	input  wire  [VALUE_W-1:0]    value,
	output logic                  done,
	output logic [VALUE_W-1:0]    result,
	output logic                  error,
	input  wire                   cfg_we,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q;
	state_t state_next;

	logic [CFG_DATA_W-1:0] modulus_q;
	logic [CFG_DATA_W-1:0] pub_exp_q;
	logic [CFG_DATA_W-1:0] priv_exp_q;

	logic [EXP_W-1:0]    exp_q;
	logic [MOD_BITS-1:0] base_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [VALUE_W-1:0]  result_q;
	logic                error_q;

	logic [MOD_BITS-1:0] mod_used;
	logic [MOD_BITS-1:0] one_mod;
	logic                err_in;

	logic                mm_start;
	logic [OP_W-1:0]     mm_a;
	logic [MOD_BITS-1:0] mm_b;
	logic                mm_done;
	logic [MOD_BITS-1:0] mm_r;

	assign mod_used = modulus_q[MOD_BITS-1:0];
	assign one_mod = (mod_used == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
	assign err_in = (mod_used == '0) ||
		((req_type == REQ_ENCRYPT) && (value >= VALUE_W'(mod_used)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
			pub_exp_q <= PUB_EXP_RST;
			priv_exp_q <= PRIV_EXP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODULUS: begin
					modulus_q <= cfg_data;
				end
				CFG_PUB_EXP: begin
					pub_exp_q <= cfg_data;
				end
				CFG_PRIV_EXP: begin
					priv_exp_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = err_in ? ST_DONE : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (mm_done) begin
					state_next = ST_STEP;
				end
			end
			ST_STEP: begin
				if (exp_q == '0) begin
					state_next = ST_DONE;
				end else if (exp_q[0]) begin
					state_next = ST_MUL;
				end else begin
					state_next = ST_SQR;
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					state_next = (exp_q[EXP_W-1:1] == '0) ? ST_STEP : ST_SQR;
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					state_next = ST_STEP;
				end
			end
			ST_DONE: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
		mm_start = 1'b0;
		mm_a = value;
		mm_b = one_mod;
		case (state_q)
			ST_IDLE: begin
				mm_start = start && !err_in;
			end
			ST_STEP: begin
				mm_start = (exp_q != '0);
				mm_a = exp_q[0] ? OP_W'(acc_q) : OP_W'(base_q);
				mm_b = base_q;
			end
			ST_MUL: begin
				mm_start = mm_done && (exp_q[EXP_W-1:1] != '0);
				mm_a = OP_W'(base_q);
				mm_b = base_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					exp_q <= (req_type == REQ_DECRYPT) ? priv_exp_q : pub_exp_q;
					if (err_in) begin
						result_q <= '0;
						error_q <= 1'b1;
					end
				end
			end
			ST_REDUCE: begin
				if (mm_done) begin
					base_q <= mm_r;
					acc_q <= MOD_BITS'(1);
				end
			end
			ST_STEP: begin
				if (exp_q == '0) begin
					result_q <= VALUE_W'(acc_q);
					error_q <= 1'b0;
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					acc_q <= mm_r;
					if (exp_q[EXP_W-1:1] == '0) begin
						exp_q <= '0;
					end
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					base_q <= mm_r;
					exp_q <= {1'b0, exp_q[EXP_W-1:1]};
				end
			end
			default: begin
			end
		endcase
	end

	rsa_mexp_mulmod #(
		.MOD_BITS(MOD_BITS)
	) u_mulmod (
		.clk(clk),
		.arst_n(arst_n),
		.start(mm_start),
		.a(mm_a),
		.b(mm_b),
		.m(mod_used),
		.done(mm_done),
		.r(mm_r)
	);

	assign result = result_q;
	assign error = error_q;

`ifndef SYNTH
	a_mm_done_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR))
		else $error("Multiplier finished outside an arithmetic state.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("Accepted transaction did not make the block busy.");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error) |-> (result == '0))
		else $error("Rejected transaction returned a nonzero result.");

	a_no_mm_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |=> !mm_done)
		else $error("Multiplier reported completion right after a launch.");
`endif

endmodule

`default_nettype wire
